### rtl/sga_pkg.sv
// Shared constants, types and the quarter-wave sine table for the star-glow sprite unit.
// No dependencies; every other file of the block imports this package.
package sga_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_SIZE  = 1024;
	localparam int SIZE_W    = 11;
	localparam int PHASE_W   = 16;
	localparam int COORD_W   = 10;
	localparam int COLOR_W   = 8;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// half-pixel distance, squared radius and fixed-point root
	localparam int DIST_W = SIZE_W;
	localparam int RAD_W  = 24;
	localparam int ROOT_W = RAD_W / 2 + FRAC_BITS;

	// divider geometry and pulse terms
	localparam int QUO_W  = 24;
	localparam int K2_W   = 24;
	localparam int IQ_W   = FRAC_BITS + 1;
	localparam int CROSS_W = 26;

	localparam logic [IQ_W-1:0] ONE_FX = IQ_W'(1 << FRAC_BITS);

	// register indexes on the configuration port
	localparam logic [2:0] REG_SIZE  = 3'd0;
	localparam logic [2:0] REG_PHASE = 3'd1;
	localparam logic [2:0] REG_RED   = 3'd2;
	localparam logic [2:0] REG_GREEN = 3'd3;
	localparam logic [2:0] REG_BLUE  = 3'd4;

	localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd64;
	localparam logic [PHASE_W-1:0] PHASE_RST = 16'd0;
	localparam logic [COLOR_W-1:0] COLOR_RST = 8'd255;

	typedef struct packed {
		logic [IQ_W-1:0] iq;
		logic [K2_W-1:0] k2;
	} pulse_t;

	// sin(k*pi/32) scaled by 65536, k = 0..16
	function automatic logic [16:0] sine_quarter(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:    v = 17'd0;
			5'd1:    v = 17'd6424;
			5'd2:    v = 17'd12785;
			5'd3:    v = 17'd19024;
			5'd4:    v = 17'd25080;
			5'd5:    v = 17'd30893;
			5'd6:    v = 17'd36410;
			5'd7:    v = 17'd41576;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd50660;
			5'd10:   v = 17'd54491;
			5'd11:   v = 17'd57798;
			5'd12:   v = 17'd60547;
			5'd13:   v = 17'd62714;
			5'd14:   v = 17'd64277;
			5'd15:   v = 17'd65220;
			5'd16:   v = 17'd65536;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/sga_if.sv
// Request channels of the star-glow unit: pixel coordinates in, RGBA pixels out.
// Depends on sga_pkg for the field widths.
interface sga_pix_if;
	import sga_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface sga_rgba_if;
	import sga_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] out_red;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_blue;
	logic [COLOR_W-1:0] out_alpha;
	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_alpha, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_alpha, output ready);
endinterface

### rtl/sga_pulse.sv
// Pulse intensity and cross-term numerator derived from the configuration registers.
// Depends on sga_pkg (sine table, pulse_t); three free-running register steps.
module sga_pulse (
	input  logic                         clk,
	input  logic [sga_pkg::PHASE_W-1:0]  phase,
	input  logic [sga_pkg::SIZE_W-1:0]   size,
	output sga_pkg::pulse_t              pulse
);
	import sga_pkg::*;

	logic [1:0]  quad;
	logic [14:0] w;
	logic [4:0]  idx;
	logic [9:0]  fr;
	logic [16:0] base;
	logic [16:0] diff;
	logic [22:0] interp;
	logic [16:0] mag;
	logic [IQ_W-1:0] iq_next;
	logic [12:0] size3;
	logic [29:0] kprod;

	logic [16:0] base_q;
	logic [22:0] interp_q;
	logic        neg_q;
	logic [IQ_W-1:0] iq_q;
	logic [K2_W-1:0] k2_q;

	always_comb begin
		quad = phase[15:14];
		// mirror the odd quadrants
		w = quad[0] ? 15'(15'h4000 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
		idx = w[14:10];
		fr = w[9:0];
		if (idx >= 5'd16) begin
			base = sine_quarter(5'd16);
			diff = 17'd0;
		end else begin
			base = sine_quarter(idx);
			diff = sine_quarter(5'(idx + 5'd1)) - base;
		end
		interp = 23'(diff[12:0]) * 23'(fr);
	end

	always_comb begin
		mag = base_q + 17'(interp_q[22:10]);
		iq_next = neg_q ? IQ_W'(17'd49152 - (mag >> 2)) : IQ_W'(17'd49152 + (mag >> 2));
		size3 = 13'({size, 1'b0}) + 13'(size);
		kprod = 30'(size3) * 30'(iq_q);
	end

	always_ff @(posedge clk) begin
		base_q <= base;
		interp_q <= interp;
		neg_q <= quad[1];
		iq_q <= iq_next;
		k2_q <= K2_W'({kprod[29:6], 1'b0});
	end

	assign pulse.iq = iq_q;
	assign pulse.k2 = k2_q;

endmodule

### rtl/sga_sqrt.sv
// Pipelined digit-by-digit square root, one result bit per stage, with side payload.
// Depends on sga_pkg for the radicand and root widths.
module sga_sqrt #(
	parameter int PW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [sga_pkg::RAD_W-1:0]   in_rad,
	input  logic [PW-1:0]               in_pay,
	output logic                        out_valid,
	output logic [sga_pkg::ROOT_W-1:0]  out_root,
	output logic [PW-1:0]               out_pay
);
	import sga_pkg::*;

	localparam int STEPS = ROOT_W;
	localparam int PAIRS = RAD_W / 2;

	logic              valid_s [0:STEPS];
	logic [RAD_W-1:0]  rad_s   [0:STEPS];
	logic [ROOT_W:0]   rem_s   [0:STEPS];
	logic [ROOT_W-1:0] root_s  [0:STEPS];
	logic [PW-1:0]     pay_s   [0:STEPS];

	assign valid_s[0] = in_valid;
	assign rad_s[0] = in_rad;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign pay_s[0] = in_pay;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [1:0]        pair;
		logic [ROOT_W+2:0] rem_n;
		logic [ROOT_W+1:0] trial;
		logic [ROOT_W+2:0] rem_sub;
		logic              ge;

		always_comb begin
			pair = (g < PAIRS) ? rad_s[g][RAD_W-1 -: 2] : 2'b00;
			rem_n = {rem_s[g], pair};
			trial = {root_s[g], 2'b01};
			ge = rem_n >= {1'b0, trial};
			rem_sub = rem_n - {1'b0, trial};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1] <= rad_s[g] << 2;
				rem_s[g+1] <= ge ? rem_sub[ROOT_W:0] : rem_n[ROOT_W:0];
				root_s[g+1] <= {root_s[g][ROOT_W-2:0], ge};
				pay_s[g+1] <= pay_s[g];
			end
		end
	end

	assign out_valid = valid_s[STEPS];
	assign out_root = root_s[STEPS];
	assign out_pay = pay_s[STEPS];

endmodule

### rtl/sga_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on sga_pkg only through the import convention; widths are parameters.
module sga_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 11,
	parameter int Q_W   = 24,
	parameter int PW    = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [PW-1:0]    in_pay,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_quo,
	output logic [PW-1:0]    out_pay
);
	import sga_pkg::*;

	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic             valid_s [0:Q_W];
	logic [NUM_W-1:0] rem_s   [0:Q_W];
	logic [DEN_W-1:0] den_s   [0:Q_W];
	logic [Q_W-1:0]   quo_s   [0:Q_W];
	logic [PW-1:0]    pay_s   [0:Q_W];

	assign valid_s[0] = in_valid;
	assign rem_s[0] = in_num;
	assign den_s[0] = in_den;
	assign quo_s[0] = '0;
	assign pay_s[0] = in_pay;

	for (genvar g = 0; g < Q_W; g++) begin : g_step
		localparam int B = Q_W - 1 - g;
		logic [CW-1:0]  shifted;
		logic [CW-1:0]  diff;
		logic           ge;
		logic [Q_W-1:0] quo_n;

		always_comb begin
			shifted = CW'(den_s[g]) << B;
			ge = CW'(rem_s[g]) >= shifted;
			diff = CW'(rem_s[g]) - shifted;
			quo_n = quo_s[g];
			quo_n[B] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? diff[NUM_W-1:0] : rem_s[g];
				den_s[g+1] <= den_s[g];
				quo_s[g+1] <= quo_n;
				pay_s[g+1] <= pay_s[g];
			end
		end
	end

	assign out_valid = valid_s[Q_W];
	assign out_quo = quo_s[Q_W];
	assign out_pay = pay_s[Q_W];

endmodule

### rtl/star_glow_sprite_alpha_unit.sv
// Star-glow sprite pixel unit: one RGBA pixel per accepted coordinate request.
// One request per cycle sustained while the output buffer is not full.
// The pipeline is built around the 28-stage square root and the 24-stage dividers that follow it.
// A two-entry output buffer lets the pipeline run on while a result waits.
// Asynchronous active-low reset clears valid bits and restores register defaults.
module star_glow_sprite_alpha_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	sga_pix_if.sink                     pixel,
	sga_rgba_if.source                  rgba,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sga_pkg::ADDR_W-1:0]  paddr,
	input  logic [sga_pkg::DATA_W-1:0]  pwdata,
	output logic [sga_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import sga_pkg::*;

	localparam logic [17:0] RECIP5 = 18'd209716;

	// configuration
	logic [SIZE_W-1:0]  size_q;
	logic [PHASE_W-1:0] phase_q;
	logic [COLOR_W-1:0] red_q;
	logic [COLOR_W-1:0] green_q;
	logic [COLOR_W-1:0] blue_q;
	logic [2:0]         reg_idx;
	logic               cfg_wr;
	logic [SIZE_W-1:0]  size_eff;
	pulse_t             pulse;

	// pipeline control
	logic en;
	logic push;
	logic pop;

	// entry and squares
	logic [SIZE_W:0]   two_x;
	logic [SIZE_W:0]   two_y;
	logic [SIZE_W:0]   sz;
	logic [DIST_W-1:0] adx;
	logic [DIST_W-1:0] ady;
	logic              valid_s1;
	logic [DIST_W-1:0] adx_s1;
	logic [DIST_W-1:0] ady_s1;
	logic              valid_s2;
	logic [RAD_W-1:0]  rad_s2;
	logic [DIST_W-1:0] adx_s2;
	logic [DIST_W-1:0] ady_s2;

	// root and dividers
	logic              root_valid;
	logic [ROOT_W-1:0] root;
	logic [DIST_W-1:0] root_adx;
	logic [DIST_W-1:0] root_ady;
	logic              outside;
	logic              ratio_valid;
	logic [QUO_W-1:0]  ratio;
	logic              ratio_out;
	logic [QUO_W-1:0]  xa_quo;
	logic              xa_zero;
	logic [QUO_W-1:0]  ya_quo;
	logic              ya_zero;

	// alpha tail
	logic                valid_s55;
	logic                dead_s55;
	logic [IQ_W-1:0]     salpha_s55;
	logic [CROSS_W-1:0]  xa_s55;
	logic [CROSS_W-1:0]  ya_s55;
	logic [51:0]         cross_prod;
	logic [33:0]         t1_prod;
	logic                valid_s56;
	logic                dead_s56;
	logic [IQ_W-1:0]     salpha_s56;
	logic [35:0]         p_s56;
	logic [17:0]         t1n_s56;
	logic [48:0]         t2_prod;
	logic [34:0]         div5_prod;
	logic                valid_s57;
	logic                dead_s57;
	logic                big_s57;
	logic [32:0]         t2raw_s57;
	logic [14:0]         t1_s57;
	logic [IQ_W-1:0]     t2;
	logic [IQ_W:0]       sum;
	logic                valid_s58;
	logic                dead_s58;
	logic [IQ_W-1:0]     tot_s58;
	logic [24:0]         scaled;
	logic [COLOR_W-1:0]  alpha;

	// output buffer
	logic               head_valid_q;
	logic               skid_valid_q;
	logic [COLOR_W-1:0] head_alpha_q;
	logic [COLOR_W-1:0] skid_alpha_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RST;
			phase_q <= PHASE_RST;
			red_q <= COLOR_RST;
			green_q <= COLOR_RST;
			blue_q <= COLOR_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SIZE:  size_q <= pwdata[SIZE_W-1:0];
				REG_PHASE: phase_q <= pwdata[PHASE_W-1:0];
				REG_RED:   red_q <= pwdata[COLOR_W-1:0];
				REG_GREEN: green_q <= pwdata[COLOR_W-1:0];
				REG_BLUE:  blue_q <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SIZE:  prdata = DATA_W'(size_q);
			REG_PHASE: prdata = DATA_W'(phase_q);
			REG_RED:   prdata = DATA_W'(red_q);
			REG_GREEN: prdata = DATA_W'(green_q);
			REG_BLUE:  prdata = DATA_W'(blue_q);
			default:   prdata = '0;
		endcase
	end

	assign size_eff = (size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;

	sga_pulse u_pulse (
		.clk   (clk),
		.phase (phase_q),
		.size  (size_eff),
		.pulse (pulse)
	);

	// ---------------- handshake ----------------
	// hold the whole pipeline only when both buffer entries are taken
	assign en = !skid_valid_q;
	assign pixel.ready = en;
	assign pop = head_valid_q && rgba.ready;
	assign push = valid_s58 && en;

	// ---------------- entry: half-pixel distances, squares ----------------
	always_comb begin
		two_x = {1'b0, pixel.pixel_x, 1'b0};
		two_y = {1'b0, pixel.pixel_y, 1'b0};
		sz = (SIZE_W+1)'(size_eff);
		adx = (two_x >= sz) ? DIST_W'(two_x - sz) : DIST_W'(sz - two_x);
		ady = (two_y >= sz) ? DIST_W'(two_y - sz) : DIST_W'(sz - two_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pixel.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1 <= adx;
			ady_s1 <= ady;
			rad_s2 <= RAD_W'(adx_s1) * RAD_W'(adx_s1) + RAD_W'(ady_s1) * RAD_W'(ady_s1);
			adx_s2 <= adx_s1;
			ady_s2 <= ady_s1;
		end
	end

	sga_sqrt #(
		.PW (2 * DIST_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.in_rad    (rad_s2),
		.in_pay    ({adx_s2, ady_s2}),
		.out_valid (root_valid),
		.out_root  (root),
		.out_pay   ({root_adx, root_ady})
	);

	// ratio at or above one means the pixel lies off the glow disc
	assign outside = root >= ROOT_W'({size_eff, FRAC_BITS'(0)});

	sga_div #(
		.NUM_W (ROOT_W),
		.DEN_W (SIZE_W),
		.Q_W   (QUO_W),
		.PW    (1)
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.in_num    (root),
		.in_den    (size_eff),
		.in_pay    (outside),
		.out_valid (ratio_valid),
		.out_quo   (ratio),
		.out_pay   (ratio_out)
	);

	sga_div #(
		.NUM_W (K2_W),
		.DEN_W (DIST_W),
		.Q_W   (QUO_W),
		.PW    (1)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.in_num    (pulse.k2),
		.in_den    (root_adx),
		.in_pay    (root_adx == '0),
		.out_valid (),
		.out_quo   (xa_quo),
		.out_pay   (xa_zero)
	);

	sga_div #(
		.NUM_W (K2_W),
		.DEN_W (DIST_W),
		.Q_W   (QUO_W),
		.PW    (1)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.in_num    (pulse.k2),
		.in_den    (root_ady),
		.in_pay    (root_ady == '0),
		.out_valid (),
		.out_quo   (ya_quo),
		.out_pay   (ya_zero)
	);

	// ---------------- alpha tail ----------------
	always_comb begin
		cross_prod = 52'(xa_s55) * 52'(ya_s55);
		t1_prod = 34'(pulse.iq) * 34'(salpha_s55);
		t2_prod = 49'(salpha_s56) * 49'(p_s56[31:0]);
		div5_prod = 35'(t1n_s56[16:0]) * 35'(RECIP5);
		t2 = (big_s57 || t2raw_s57 > 33'(ONE_FX)) ? ONE_FX : t2raw_s57[IQ_W-1:0];
		sum = (IQ_W+1)'(t1_s57) + (IQ_W+1)'(t2);
		scaled = {tot_s58, 8'b0} - 25'(tot_s58);
		alpha = dead_s58 ? '0 : scaled[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s55 <= 1'b0;
			valid_s56 <= 1'b0;
			valid_s57 <= 1'b0;
			valid_s58 <= 1'b0;
		end else if (en) begin
			valid_s55 <= ratio_valid;
			valid_s56 <= valid_s55;
			valid_s57 <= valid_s56;
			valid_s58 <= valid_s57;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dead_s55 <= ratio_out;
			salpha_s55 <= ONE_FX - IQ_W'(ratio[FRAC_BITS-1:0]);
			// on the centre line the cross term is the half size
			xa_s55 <= xa_zero ? CROSS_W'({size_eff, 15'b0}) : CROSS_W'(xa_quo);
			ya_s55 <= ya_zero ? CROSS_W'({size_eff, 15'b0}) : CROSS_W'(ya_quo);

			dead_s56 <= dead_s55;
			salpha_s56 <= salpha_s55;
			p_s56 <= cross_prod[51:16];
			t1n_s56 <= t1_prod[33:16];

			dead_s57 <= dead_s56;
			// a product of 2^32 or more saturates the second term
			big_s57 <= |p_s56[35:32];
			t2raw_s57 <= t2_prod[48:16];
			t1_s57 <= div5_prod[34:20];

			dead_s58 <= dead_s57;
			tot_s58 <= (sum > (IQ_W+1)'(ONE_FX)) ? ONE_FX : sum[IQ_W-1:0];
		end
	end

	// ---------------- output buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			head_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			head_valid_q <= 1'b1;
			skid_valid_q <= head_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_alpha_q <= skid_valid_q ? skid_alpha_q : alpha;
		end else if (push && !head_valid_q) begin
			head_alpha_q <= alpha;
		end
		if (push && head_valid_q && !pop) begin
			skid_alpha_q <= alpha;
		end
	end

	assign rgba.valid = head_valid_q;
	assign rgba.out_red = red_q;
	assign rgba.out_green = green_q;
	assign rgba.out_blue = blue_q;
	assign rgba.out_alpha = head_alpha_q;

	// ---------------- assertions ----------------
	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> head_valid_q)
		else $error("skid entry held without a head entry");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s58 && skid_valid_q |=> valid_s58 && $stable(tot_s58))
		else $error("final stage moved while the buffer was full");

	a_refill_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop && skid_valid_q |=> head_valid_q && !skid_valid_q)
		else $error("skid entry lost on pop");

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push && dead_s58 && !head_valid_q |=> head_alpha_q == '0)
		else $error("pixel off the disc gave non-zero alpha");

endmodule
